// File: sv/bds2_pkg.sv
// Shared types and constants for the 2x2 box downsample block.
package bds2_pkg;

    // Channel and accumulator widths
    localparam int CHAN_BITS  = 16;
    localparam int SUM_BITS   = CHAN_BITS + 1;
    localparam int TOTAL_BITS = CHAN_BITS + 2;

    // Configuration port
    localparam int CFG_W      = 11;
    localparam int CFG_ADDR_W = 2;

    // Fixed row limit of the source level
    localparam int MAX_HEIGHT = 1024;
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int ROW_DW     = ROW_W + 1;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1
    } cfg_reg_t;

    // One source pixel
    typedef struct packed {
        logic signed [CHAN_BITS-1:0] chan_r;
        logic signed [CHAN_BITS-1:0] chan_g;
        logic signed [CHAN_BITS-1:0] chan_b;
        logic signed [CHAN_BITS-1:0] chan_a;
    } pix_in_t;

    // One pixel of the coarser level
    typedef struct packed {
        logic signed [CHAN_BITS-1:0] avg_r;
        logic signed [CHAN_BITS-1:0] avg_g;
        logic signed [CHAN_BITS-1:0] avg_b;
        logic signed [CHAN_BITS-1:0] avg_a;
        logic                        frame_end;
    } pix_out_t;

    // One line store entry: horizontal pair sums of an even row
    typedef struct packed {
        logic signed [SUM_BITS-1:0] sum_r;
        logic signed [SUM_BITS-1:0] sum_g;
        logic signed [SUM_BITS-1:0] sum_b;
        logic signed [SUM_BITS-1:0] sum_a;
    } line_word_t;

    // Line store access strobes
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } line_ctl_t;

endpackage

// File: sv/bds2_line_ram.sv
// Line store RAM: one write port, one read port, registered read data.
module bds2_line_ram #(
    parameter int DEPTH  = 512,
    parameter int ADDR_W = 9
) (
    input  logic                  aclk,
    input  bds2_pkg::line_ctl_t   ctl,
    input  logic [ADDR_W-1:0]     wr_addr,
    input  bds2_pkg::line_word_t  wr_data,
    input  logic [ADDR_W-1:0]     rd_addr,
    output bds2_pkg::line_word_t  rd_data
);

    bds2_pkg::line_word_t mem [DEPTH];

    // Write pair sums of the even row
    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read ahead for the odd row; data holds until the next read
    always_ff @(posedge aclk) begin
        if (ctl.rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: sv/box_downsample_2x2_unit.sv
// Top level of the 2x2 box downsample (mipmap) block.
//
//  channel  | ports                        | direction | beat
//  ---------+------------------------------+-----------+---------------------------
//  source   | s_valid s_ready s_data       | in        | one source pixel, raster
//  result   | m_valid m_ready m_data       | out       | one 2x2 mean pixel
//  config   | cfg_wr_en cfg_addr cfg_wr_data | in      | width / height write
//
// One source pixel is taken per cycle while s_ready is high. The line store is
// read one beat ahead, when the left pixel of an odd-row pair arrives, so the
// right pixel finds the stored even-row sum waiting in the RAM read register.
// Results land in a single output register; s_ready stays high while that
// register is empty or drains in the same cycle. Reset clears counters and
// output valid; the line store needs no clearing.
module box_downsample_2x2_unit #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // source pixels
    input  logic                              s_valid,
    output logic                              s_ready,
    input  bds2_pkg::pix_in_t                 s_data,
    // result pixels
    output logic                              m_valid,
    input  logic                              m_ready,
    output bds2_pkg::pix_out_t                m_data,
    // configuration
    input  logic                              cfg_wr_en,
    input  logic [bds2_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [bds2_pkg::CFG_W-1:0]        cfg_wr_data
);

    localparam int CNT_W  = $clog2(MAX_WIDTH);
    localparam int DW     = CNT_W + 1;
    localparam int SLOT_W = CNT_W - 1;
    localparam int DEPTH  = MAX_WIDTH / 2;

    localparam int CB = bds2_pkg::CHAN_BITS;
    localparam int SB = bds2_pkg::SUM_BITS;
    localparam int TB = bds2_pkg::TOTAL_BITS;

    // Configuration registers
    logic [bds2_pkg::CFG_W-1:0] width_reg;
    logic [bds2_pkg::CFG_W-1:0] height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= bds2_pkg::CFG_W'(1024);
            height_reg <= bds2_pkg::CFG_W'(1024);
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                bds2_pkg::REG_IMAGE_WIDTH:  width_reg  <= cfg_wr_data;
                bds2_pkg::REG_IMAGE_HEIGHT: height_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // Clamp dimensions into the supported range
    logic [31:0]                  width_ext;
    logic [31:0]                  height_ext;
    logic [DW-1:0]                w_lim;
    logic [bds2_pkg::ROW_DW-1:0]  h_lim;
    logic [DW-1:0]                w_even;
    logic [bds2_pkg::ROW_DW-1:0]  h_even;

    always_comb begin
        width_ext  = {{(32 - bds2_pkg::CFG_W){1'b0}}, width_reg};
        height_ext = {{(32 - bds2_pkg::CFG_W){1'b0}}, height_reg};
        if (width_ext < 32'd2) begin
            w_lim = DW'(2);
        end else if (width_ext > 32'(MAX_WIDTH)) begin
            w_lim = DW'(MAX_WIDTH);
        end else begin
            w_lim = width_ext[DW-1:0];
        end
        if (height_ext < 32'd2) begin
            h_lim = bds2_pkg::ROW_DW'(2);
        end else if (height_ext > 32'(bds2_pkg::MAX_HEIGHT)) begin
            h_lim = bds2_pkg::ROW_DW'(bds2_pkg::MAX_HEIGHT);
        end else begin
            h_lim = height_ext[bds2_pkg::ROW_DW-1:0];
        end
        w_even = {w_lim[DW-1:1], 1'b0};
        h_even = {h_lim[bds2_pkg::ROW_DW-1:1], 1'b0};
    end

    // Raster position
    logic [CNT_W-1:0]             col_reg, col_next;
    logic [bds2_pkg::ROW_W-1:0]   row_reg, row_next;
    logic [DW-1:0]                col_ext;
    logic [bds2_pkg::ROW_DW-1:0]  row_ext;
    logic                         in_range;
    logic                         accept;

    assign accept   = s_valid && s_ready;
    assign col_ext  = {1'b0, col_reg};
    assign row_ext  = {1'b0, row_reg};
    assign in_range = (col_ext < w_even) && (row_ext < h_even);

    // Advance column, wrap rows and frames
    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (col_ext + DW'(1) >= w_lim) begin
            col_next = '0;
            if (row_ext + bds2_pkg::ROW_DW'(1) >= h_lim) begin
                row_next = '0;
            end else begin
                row_next = row_reg + bds2_pkg::ROW_W'(1);
            end
        end else begin
            col_next = col_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (accept) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Hold the left pixel of the current pair; pixels outside every block leave it alone
    bds2_pkg::pix_in_t left_reg;

    always_ff @(posedge aclk) begin
        if (accept && in_range && !col_reg[0]) begin
            left_reg <= s_data;
        end
    end

    // Horizontal pair sums
    bds2_pkg::line_word_t pair;

    always_comb begin
        pair.sum_r = {left_reg.chan_r[CB-1], left_reg.chan_r}
                   + {s_data.chan_r[CB-1], s_data.chan_r};
        pair.sum_g = {left_reg.chan_g[CB-1], left_reg.chan_g}
                   + {s_data.chan_g[CB-1], s_data.chan_g};
        pair.sum_b = {left_reg.chan_b[CB-1], left_reg.chan_b}
                   + {s_data.chan_b[CB-1], s_data.chan_b};
        pair.sum_a = {left_reg.chan_a[CB-1], left_reg.chan_a}
                   + {s_data.chan_a[CB-1], s_data.chan_a};
    end

    // Line store: write on even rows, read ahead on every left pixel of an odd
    // row, so a block that comes into range mid-pair still finds its slot.
    // Writes and reads of one slot fall in different rows, so they never share
    // a clock edge.
    bds2_pkg::line_ctl_t   line_ctl;
    bds2_pkg::line_word_t  line_rd;
    logic [SLOT_W-1:0]     slot;

    assign slot           = col_reg[CNT_W-1:1];
    assign line_ctl.wr_en = accept && in_range && !row_reg[0] && col_reg[0];
    assign line_ctl.rd_en = accept && row_reg[0] && !col_reg[0];

    bds2_line_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (SLOT_W)
    ) u_line_ram (
        .aclk    (aclk),
        .ctl     (line_ctl),
        .wr_addr (slot),
        .wr_data (pair),
        .rd_addr (slot),
        .rd_data (line_rd)
    );

    // Four-pixel totals; mean is the total shifted right by two
    logic signed [TB-1:0] tot_r, tot_g, tot_b, tot_a;
    logic                 emit;
    logic                 last_pix;

    assign tot_r = {line_rd.sum_r[SB-1], line_rd.sum_r} + {pair.sum_r[SB-1], pair.sum_r};
    assign tot_g = {line_rd.sum_g[SB-1], line_rd.sum_g} + {pair.sum_g[SB-1], pair.sum_g};
    assign tot_b = {line_rd.sum_b[SB-1], line_rd.sum_b} + {pair.sum_b[SB-1], pair.sum_b};
    assign tot_a = {line_rd.sum_a[SB-1], line_rd.sum_a} + {pair.sum_a[SB-1], pair.sum_a};

    assign emit     = accept && in_range && row_reg[0] && col_reg[0];
    assign last_pix = (col_ext == w_even - DW'(1))
                   && (row_ext == h_even - bds2_pkg::ROW_DW'(1));

    // Output register
    logic               m_valid_reg, m_valid_next;
    bds2_pkg::pix_out_t m_data_reg;

    assign s_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (emit) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_data_reg.avg_r     <= tot_r[TB-1:2];
            m_data_reg.avg_g     <= tot_g[TB-1:2];
            m_data_reg.avg_b     <= tot_b[TB-1:2];
            m_data_reg.avg_a     <= tot_a[TB-1:2];
            m_data_reg.frame_end <= last_pix;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
